// ===== hdl/qmm_pkg.sv =====
// qmm_pkg: shared types and constants of the quad motor mixer
package qmm_pkg;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 16;
  localparam int CMD_W   = 12;
  localparam int GEOM_W  = 64;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;
  localparam int MOTORS  = 4;
  localparam int AXES    = 4;
  localparam int DIGIT_W = 4;
  localparam int FRAC_W  = 24;
  localparam int SUM_W   = 34;
  localparam int PROD_W  = 48;
  localparam int PP_W    = SUM_W + DIGIT_W + 1;
  localparam int SPAN_W  = CMD_W + 1;
  localparam int VAL_W   = PROD_W + 2;

  localparam logic [KIND_W-1:0] KIND_ROLL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PITCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_YAW    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_THRUST = 2'd3;

  localparam logic [IDX_W-1:0] REG_GEOM_ROW0     = 3'd0;
  localparam logic [IDX_W-1:0] REG_GEOM_ROW1     = 3'd1;
  localparam logic [IDX_W-1:0] REG_GEOM_ROW2     = 3'd2;
  localparam logic [IDX_W-1:0] REG_GEOM_ROW3     = 3'd3;
  localparam logic [IDX_W-1:0] REG_ESC_MAX       = 3'd4;
  localparam logic [IDX_W-1:0] REG_ESC_MIN_ARMED = 3'd5;
  localparam logic [IDX_W-1:0] REG_ESC_MIN       = 3'd6;
  localparam logic [IDX_W-1:0] REG_ARMED         = 3'd7;

  localparam logic [CMD_W-1:0] ESC_MAX_RST       = 12'd2000;
  localparam logic [CMD_W-1:0] ESC_MIN_ARMED_RST = 12'd1150;
  localparam logic [CMD_W-1:0] ESC_MIN_RST       = 12'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_SCALE,
    ST_CLAMP
  } state_t;

endpackage

// ===== hdl/qmm_if.sv =====
// qmm_if: valid/ready channels for axis items and motor command results
interface qmm_item_if;
  logic                                valid;
  logic                                ready;
  logic        [qmm_pkg::KIND_W-1:0]   kind;
  logic signed [qmm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface qmm_result_if;
  logic                        valid;
  logic                        ready;
  logic [qmm_pkg::CMD_W-1:0]   cmd_motor0;
  logic [qmm_pkg::CMD_W-1:0]   cmd_motor1;
  logic [qmm_pkg::CMD_W-1:0]   cmd_motor2;
  logic [qmm_pkg::CMD_W-1:0]   cmd_motor3;
  logic                        armed_flag;

  modport source (output valid, output cmd_motor0, output cmd_motor1, output cmd_motor2,
                  output cmd_motor3, output armed_flag, input ready);
  modport sink   (input valid, input cmd_motor0, input cmd_motor1, input cmd_motor2,
                  input cmd_motor3, input armed_flag, output ready);
endinterface

// ===== hdl/quad_motor_mixer_core.sv =====
// quad_motor_mixer_core: four-lane digit-serial motor mixer with config registers
// steps: a pitch beat passes through mac, acc, scale and clamp before its result is
//   registered; four-bit digits of the multiplier shift through one register
// throughput: a pitch beat holds off all beats until clamp ends; roll, yaw and thrust beats
//   one per cycle while idle; the output register lets a beat in while a result waits
// reset: config registers take their defaults, latched axes clear, no clearing pass
module quad_motor_mixer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qmm_pkg::IDX_W-1:0]       cfg_index,
  input  logic [qmm_pkg::CFG_W-1:0]       cfg_data,
  qmm_item_if.sink                        item,
  qmm_result_if.source                    result
);

  qmm_pkg::state_t state, state_next;

  logic [qmm_pkg::GEOM_W-1:0]         geom [qmm_pkg::MOTORS];
  logic [qmm_pkg::CMD_W-1:0]          esc_max;
  logic [qmm_pkg::CMD_W-1:0]          esc_min_armed;
  logic [qmm_pkg::CMD_W-1:0]          esc_min;
  logic                               armed;

  logic signed [qmm_pkg::VALUE_W-1:0] axis_values [qmm_pkg::AXES];

  logic [1:0]                         axis_cnt;
  logic [1:0]                         dig_cnt;
  logic [qmm_pkg::VALUE_W-1:0]        bsr;

  logic signed [qmm_pkg::SUM_W-1:0]   sum  [qmm_pkg::MOTORS];
  logic signed [qmm_pkg::PROD_W-1:0]  p    [qmm_pkg::MOTORS];
  logic signed [qmm_pkg::PP_W-1:0]    pp   [qmm_pkg::MOTORS];
  logic [qmm_pkg::CMD_W-1:0]          clamp_cmd [qmm_pkg::MOTORS];

  logic                               ovalid;
  logic [qmm_pkg::CMD_W-1:0]          ocmd [qmm_pkg::MOTORS];
  logic                               oarmed;

  logic                               in_fire;
  logic                               load_out;
  logic                               last_dig;
  logic signed [qmm_pkg::DIGIT_W:0]   digit;
  logic signed [qmm_pkg::SPAN_W-1:0]  span;

  assign in_fire  = item.valid && item.ready;
  assign last_dig = (dig_cnt == 2'd3);
  assign digit    = (dig_cnt == 2'd0) ? {bsr[15], bsr[15:12]} : {1'b0, bsr[15:12]};
  assign span     = $signed({1'b0, esc_max}) - $signed({1'b0, esc_min_armed});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      qmm_pkg::ST_IDLE: begin
        if (in_fire && item.kind == qmm_pkg::KIND_PITCH) state_next = qmm_pkg::ST_MAC;
      end
      qmm_pkg::ST_MAC: begin
        if (last_dig && axis_cnt == 2'd3) state_next = qmm_pkg::ST_ACC;
      end
      qmm_pkg::ST_ACC:   state_next = qmm_pkg::ST_SCALE;
      qmm_pkg::ST_SCALE: begin
        if (last_dig) state_next = qmm_pkg::ST_CLAMP;
      end
      qmm_pkg::ST_CLAMP: begin
        if (load_out) state_next = qmm_pkg::ST_IDLE;
      end
      default: state_next = qmm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item.ready = 1'b0;
    load_out   = 1'b0;
    case (state)
      qmm_pkg::ST_IDLE:  item.ready = !rst;
      qmm_pkg::ST_CLAMP: load_out = !ovalid || result.ready;
      default: begin
        item.ready = 1'b0;
        load_out   = 1'b0;
      end
    endcase
  end

  // one narrow multiplier per motor lane
  for (genvar m = 0; m < qmm_pkg::MOTORS; m++) begin : g_lane
    logic signed [qmm_pkg::SUM_W-1:0] a_op;
    logic [qmm_pkg::VALUE_W-1:0]      coef;
    logic signed [qmm_pkg::VAL_W-1:0] val;
    logic signed [qmm_pkg::VAL_W-1:0] lo;
    logic signed [qmm_pkg::VAL_W-1:0] hi;

    assign coef = geom[m][{axis_cnt, 4'b0000} +: qmm_pkg::VALUE_W];
    assign a_op = (state == qmm_pkg::ST_SCALE) ? sum[m]
                : {{(qmm_pkg::SUM_W - qmm_pkg::VALUE_W){coef[15]}}, coef};
    assign pp[m] = a_op * digit;

    assign lo  = $signed({{(qmm_pkg::VAL_W - qmm_pkg::CMD_W - qmm_pkg::FRAC_W){1'b0}},
                          esc_min_armed, {qmm_pkg::FRAC_W{1'b0}}});
    assign hi  = $signed({{(qmm_pkg::VAL_W - qmm_pkg::CMD_W - qmm_pkg::FRAC_W){1'b0}},
                          esc_max, {qmm_pkg::FRAC_W{1'b0}}});
    assign val = {{2{p[m][qmm_pkg::PROD_W-1]}}, p[m]} + lo;

    always_comb begin
      if (!armed) begin
        clamp_cmd[m] = esc_min;
      end else if (val > hi) begin
        clamp_cmd[m] = esc_max;
      end else if (p[m][qmm_pkg::PROD_W-1]) begin
        clamp_cmd[m] = esc_min_armed;
      end else begin
        clamp_cmd[m] = val[qmm_pkg::FRAC_W +: qmm_pkg::CMD_W];
      end
    end

    always_ff @(posedge clk) begin
      if (state == qmm_pkg::ST_MAC || state == qmm_pkg::ST_SCALE) begin
        if (dig_cnt == 2'd0) begin
          p[m] <= {{(qmm_pkg::PROD_W - qmm_pkg::PP_W){pp[m][qmm_pkg::PP_W-1]}}, pp[m]};
        end else begin
          p[m] <= (p[m] <<< qmm_pkg::DIGIT_W)
                + {{(qmm_pkg::PROD_W - qmm_pkg::PP_W){pp[m][qmm_pkg::PP_W-1]}}, pp[m]};
        end
      end
      if (state == qmm_pkg::ST_MAC && dig_cnt == 2'd0) begin
        if (axis_cnt == 2'd0) begin
          sum[m] <= '0;
        end else begin
          sum[m] <= sum[m] + p[m][qmm_pkg::SUM_W-1:0];
        end
      end else if (state == qmm_pkg::ST_ACC) begin
        sum[m] <= sum[m] + p[m][qmm_pkg::SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= qmm_pkg::ST_IDLE;
      axis_cnt      <= '0;
      dig_cnt       <= '0;
      ovalid        <= 1'b0;
      esc_max       <= qmm_pkg::ESC_MAX_RST;
      esc_min_armed <= qmm_pkg::ESC_MIN_ARMED_RST;
      esc_min       <= qmm_pkg::ESC_MIN_RST;
      armed         <= 1'b0;
      for (int i = 0; i < qmm_pkg::MOTORS; i++) geom[i] <= '0;
      for (int i = 0; i < qmm_pkg::AXES; i++) axis_values[i] <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          qmm_pkg::REG_GEOM_ROW0:     geom[0] <= cfg_data;
          qmm_pkg::REG_GEOM_ROW1:     geom[1] <= cfg_data;
          qmm_pkg::REG_GEOM_ROW2:     geom[2] <= cfg_data;
          qmm_pkg::REG_GEOM_ROW3:     geom[3] <= cfg_data;
          qmm_pkg::REG_ESC_MAX:       esc_max <= cfg_data[qmm_pkg::CMD_W-1:0];
          qmm_pkg::REG_ESC_MIN_ARMED: esc_min_armed <= cfg_data[qmm_pkg::CMD_W-1:0];
          qmm_pkg::REG_ESC_MIN:       esc_min <= cfg_data[qmm_pkg::CMD_W-1:0];
          qmm_pkg::REG_ARMED:         armed <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_fire) axis_values[item.kind] <= item.value;

      if (state == qmm_pkg::ST_MAC || state == qmm_pkg::ST_SCALE) begin
        dig_cnt <= dig_cnt + 2'd1;
        if (state == qmm_pkg::ST_MAC && last_dig) axis_cnt <= axis_cnt + 2'd1;
      end else begin
        dig_cnt  <= '0;
        axis_cnt <= '0;
      end

      if (load_out) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // multiplier digit shift register, top digit first
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bsr <= axis_values[0];
    end else if (state == qmm_pkg::ST_MAC && last_dig) begin
      bsr <= axis_values[axis_cnt + 2'd1];
    end else if (state == qmm_pkg::ST_ACC) begin
      bsr <= {{(qmm_pkg::VALUE_W - qmm_pkg::SPAN_W){span[qmm_pkg::SPAN_W-1]}}, span};
    end else begin
      bsr <= bsr << qmm_pkg::DIGIT_W;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < qmm_pkg::MOTORS; i++) ocmd[i] <= clamp_cmd[i];
      oarmed <= armed;
    end
  end

  assign result.valid      = ovalid;
  assign result.cmd_motor0 = ocmd[0];
  assign result.cmd_motor1 = ocmd[1];
  assign result.cmd_motor2 = ocmd[2];
  assign result.cmd_motor3 = ocmd[3];
  assign result.armed_flag = oarmed;

endmodule

// ===== sim/qmm_checker.sv =====
// qmm_checker: predicts motor command beats of the quad motor mixer and compares them
`timescale 1ns / 100ps
module qmm_checker
  import qmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  qmm_item_if                   item,
  qmm_result_if                 result,
  output int unsigned           errors,
  output int unsigned           outstanding
);

  typedef struct packed {
    logic [MOTORS-1:0][CMD_W-1:0] cmd;
    logic                         armed;
  } motor_cmd_t;

  logic [GEOM_W-1:0]         geom_rows [MOTORS];
  logic [CMD_W-1:0]          esc_max_q;
  logic [CMD_W-1:0]          esc_min_armed_q;
  logic [CMD_W-1:0]          esc_min_q;
  logic                      armed_q;
  logic signed [VALUE_W-1:0] axis_latch [AXES];
  motor_cmd_t                cmd_queue [$];

  function automatic logic [CMD_W-1:0] mix_motor(logic [GEOM_W-1:0] row);
    longint                    acc;
    longint                    span;
    longint                    hi;
    longint                    lo;
    longint                    scaled;
    logic signed [VALUE_W-1:0] coef;
    int                        a;
    acc = 0;
    for (a = 0; a < AXES; a++) begin
      coef = row[VALUE_W*a +: VALUE_W];
      acc += longint'(coef) * longint'(axis_latch[a]);
    end
    span   = longint'(esc_max_q) - longint'(esc_min_armed_q);
    hi     = longint'(esc_max_q) <<< FRAC_W;
    lo     = longint'(esc_min_armed_q) <<< FRAC_W;
    scaled = acc * span + lo;
    if (scaled > hi) return esc_max_q;
    if (scaled < lo) return esc_min_armed_q;
    return scaled[FRAC_W +: CMD_W];
  endfunction

  function automatic motor_cmd_t predict_commands();
    motor_cmd_t p;
    int         m;
    for (m = 0; m < MOTORS; m++) begin
      p.cmd[m] = armed_q ? mix_motor(geom_rows[m]) : esc_min_q;
    end
    p.armed = armed_q;
    return p;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) geom_rows[i] = '0;
      for (int i = 0; i < AXES; i++) axis_latch[i] = '0;
      esc_max_q       = ESC_MAX_RST;
      esc_min_armed_q = ESC_MIN_ARMED_RST;
      esc_min_q       = ESC_MIN_RST;
      armed_q         = 1'b0;
      cmd_queue.delete();
      errors          = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GEOM_ROW0:     geom_rows[0]    = cfg_data;
          REG_GEOM_ROW1:     geom_rows[1]    = cfg_data;
          REG_GEOM_ROW2:     geom_rows[2]    = cfg_data;
          REG_GEOM_ROW3:     geom_rows[3]    = cfg_data;
          REG_ESC_MAX:       esc_max_q       = cfg_data[CMD_W-1:0];
          REG_ESC_MIN_ARMED: esc_min_armed_q = cfg_data[CMD_W-1:0];
          REG_ESC_MIN:       esc_min_q       = cfg_data[CMD_W-1:0];
          REG_ARMED:         armed_q         = cfg_data[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        axis_latch[item.kind] = item.value;
        if (item.kind == KIND_PITCH) cmd_queue.push_back(predict_commands());
      end
      if (result.valid && result.ready) begin
        if (cmd_queue.size() == 0) begin
          $error("result beat with no command expected");
          errors++;
        end else begin
          want = cmd_queue.pop_front();
          check_field("cmd_motor0", 32'(want.cmd[0]), 32'(result.cmd_motor0));
          check_field("cmd_motor1", 32'(want.cmd[1]), 32'(result.cmd_motor1));
          check_field("cmd_motor2", 32'(want.cmd[2]), 32'(result.cmd_motor2));
          check_field("cmd_motor3", 32'(want.cmd[3]), 32'(result.cmd_motor3));
          check_field("armed_flag", 32'(want.armed), 32'(result.armed_flag));
        end
      end
    end
    outstanding = cmd_queue.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: clock, reset, config phases and axis stimulus for the quad motor mixer
`timescale 1ns / 100ps
module tb_top;
  import qmm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_GAP       = 18;
  localparam int SRC_SIDE      = 0;
  localparam int SNK_SIDE      = 1;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int unsigned       errors;
  int unsigned       outstanding;
  int unsigned       cycle_count = 0;
  bit                steady [2];

  qmm_item_if   item_ch ();
  qmm_result_if result_ch ();

  quad_motor_mixer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  qmm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (item_ch),
    .result      (result_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stretches of back-to-back beats come from flipping the steady flag now and then
  function automatic int unsigned draw_gap(int side);
    if ($urandom_range(0, 39) == 0) steady[side] = !steady[side];
    return steady[side] ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_q();
    case ($urandom_range(0, 9))
      0:       return VALUE_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      default: return VALUE_W'($urandom_range(0, 8192)) - 16'sd4096;
    endcase
  endfunction

  function automatic logic [GEOM_W-1:0] pack_row(logic [15:0] roll, logic [15:0] pitch,
                                                 logic [15:0] yaw, logic [15:0] thrust);
    return {thrust, yaw, pitch, roll};
  endfunction

  function automatic logic [GEOM_W-1:0] rand_row();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return pack_row(VALUE_W'($urandom_range(0, 4096)) - 16'd2048,
                    VALUE_W'($urandom_range(0, 4096)) - 16'd2048,
                    VALUE_W'($urandom_range(0, 4096)) - 16'd2048,
                    VALUE_W'($urandom_range(0, 4096)));
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_all(logic [GEOM_W-1:0] r0, logic [GEOM_W-1:0] r1,
                         logic [GEOM_W-1:0] r2, logic [GEOM_W-1:0] r3,
                         logic [CMD_W-1:0] top, logic [CMD_W-1:0] floor_armed,
                         logic [CMD_W-1:0] idle_cmd, logic arm);
    write_reg(REG_GEOM_ROW0, r0);
    write_reg(REG_GEOM_ROW1, r1);
    write_reg(REG_GEOM_ROW2, r2);
    write_reg(REG_GEOM_ROW3, r3);
    write_reg(REG_ESC_MAX, CFG_W'(top));
    write_reg(REG_ESC_MIN_ARMED, CFG_W'(floor_armed));
    write_reg(REG_ESC_MIN, CFG_W'(idle_cmd));
    write_reg(REG_ARMED, CFG_W'(arm));
  endtask

  task automatic send_item(logic [KIND_W-1:0] k, logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = draw_gap(SRC_SIDE);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind  <= k;
    item_ch.value <= v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(KIND_ROLL, 16'sh7FFF);
    send_item(KIND_YAW, 16'sh8000);
    send_item(KIND_THRUST, 16'sh7FFF);
    send_item(KIND_PITCH, 16'sh8000);
    send_item(KIND_PITCH, 16'sh7FFF);
    send_item(KIND_ROLL, 16'sh0000);
    send_item(KIND_YAW, 16'sh0000);
    send_item(KIND_THRUST, 16'sh0800);
    send_item(KIND_PITCH, 16'sh0000);
    send_item(KIND_ROLL, 16'shFFFF);
    send_item(KIND_THRUST, 16'sh8000);
    send_item(KIND_PITCH, 16'sh0001);
  endtask

  // mostly full roll/yaw/thrust/pitch frames, the rest single beats of any kind
  task automatic run_random(int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        send_item(KIND_ROLL, rand_q());
        send_item(KIND_YAW, rand_q());
        send_item(KIND_THRUST, rand_q());
        send_item(KIND_PITCH, rand_q());
        sent += 4;
      end else begin
        send_item(KIND_W'($urandom_range(0, 3)), rand_q());
        sent += 1;
      end
    end
    settle();
  endtask

  initial begin
    int            n;
    logic [CMD_W-1:0] top;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_GEOM_ROW0;
    cfg_data         = '0;
    item_ch.valid    = 1'b0;
    item_ch.kind     = KIND_ROLL;
    item_ch.value    = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // defaults after reset, disarmed
    run_directed();
    run_random(60);

    // plain x frame, armed
    set_all(pack_row(16'hFC00, 16'h0400, 16'h0400, 16'h1000),
            pack_row(16'h0400, 16'h0400, 16'hFC00, 16'h1000),
            pack_row(16'h0400, 16'hFC00, 16'h0400, 16'h1000),
            pack_row(16'hFC00, 16'hFC00, 16'hFC00, 16'h1000),
            12'd2000, 12'd1150, 12'd1000, 1'b1);
    run_directed();
    settle();
    run_random(150);

    // full-scale coefficients, widest span
    set_all(pack_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000),
            pack_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF),
            pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
            pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
            12'd4095, 12'd0, 12'd4095, 1'b1);
    run_random(100);

    // inverted bounds
    set_all(rand_row(), rand_row(), rand_row(), rand_row(), 12'd1000, 12'd3000, 12'd0, 1'b1);
    run_random(100);

    // zero span
    set_all(rand_row(), rand_row(), rand_row(), rand_row(), 12'd0, 12'd0, 12'd0, 1'b1);
    run_random(60);

    // disarmed with odd idle command
    set_all(rand_row(), rand_row(), rand_row(), rand_row(),
            CMD_W'($urandom), CMD_W'($urandom), CMD_W'($urandom), 1'b0);
    run_random(60);

    for (n = 0; n < 4; n++) begin
      top = CMD_W'($urandom_range(1, 4095));
      set_all(rand_row(), rand_row(), rand_row(), rand_row(), top,
              ($urandom_range(0, 4) == 0) ? CMD_W'($urandom) : CMD_W'($urandom_range(0, top)),
              CMD_W'($urandom), ($urandom_range(0, 4) != 0));
      run_random(80);
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = draw_gap(SNK_SIDE);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

endmodule

// ===== sim.f =====
hdl/qmm_pkg.sv
hdl/qmm_if.sv
hdl/quad_motor_mixer_core.sv
sim/qmm_checker.sv
sim/tb_top.sv
